[src/ctps_pkg.sv]
// Shared types and constants for the capture timestamp period statistics block.
// No dependencies; imported by the front, queue, back and top-level modules.
`default_nettype none
package ctps_pkg;

    localparam int unsigned STAMP_W  = 64;
    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned RATIO_W  = 32;
    localparam int unsigned Q_SHIFT  = 16;
    localparam int unsigned PROD_W   = COUNT_W + RATIO_W;

    localparam logic REQ_EDGE  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [RATIO_W-1:0]  RATIO_RESET = 32'h0001_0000;
    localparam logic [PERIOD_W-1:0] PERIOD_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               req_type;
        logic [STAMP_W-1:0] stamp;
    } t_evt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

[src/capture_timestamp_period_stats.sv]
// Top level of the capture timestamp period statistics block.
// Instantiates ctps_front, ctps_queue and ctps_back; uses ctps_pkg.
//
// Accepts one request per clock while o_stall is low and delivers one
// result per request. A request is registered in the front stage (latch
// age times ratio), then passes a QUEUE_DEPTH-entry queue and the
// statistics update, whose result is held in the output register. The
// sustained rate of one item per cycle, when i_stall is low, is set by
// the statistics update. The ratio register is written through the
// configuration port and must only change while the block is idle.
`default_nettype none
module capture_timestamp_period_stats #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_req_type,
    input  wire logic [ctps_pkg::COUNT_W-1:0]  i_captured_count,
    input  wire logic [ctps_pkg::COUNT_W-1:0]  i_counter_now,
    input  wire logic [ctps_pkg::STAMP_W-1:0]  i_base_now,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [ctps_pkg::STAMP_W-1:0]       o_edge_stamp,
    output logic [ctps_pkg::PERIOD_W-1:0]      o_period_last,
    output logic [ctps_pkg::PERIOD_W-1:0]      o_period_low,
    output logic [ctps_pkg::PERIOD_W-1:0]      o_period_high,
    output logic [ctps_pkg::PERIOD_W-1:0]      o_edge_total,
    output logic                               o_period_valid,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ctps_pkg::RATIO_W-1:0]  i_cfg_data
);
    import ctps_pkg::*;

    logic [RATIO_W-1:0] r_ratio_q16;
    t_evt               push_data;
    t_evt               pop_data;
    t_q_stat            q_stat;
    logic               q_push;
    logic               q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_q16 <= RATIO_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ratio_q16 <= i_cfg_data;
        end
    end

    ctps_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_captured_count (i_captured_count),
        .i_counter_now    (i_counter_now),
        .i_base_now       (i_base_now),
        .i_ratio_q16      (r_ratio_q16),
        .i_q_stat         (q_stat),
        .o_q_push         (q_push),
        .o_q_data         (push_data)
    );

    ctps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_data),
        .i_pop   (q_pop),
        .o_data  (pop_data),
        .o_stat  (q_stat)
    );

    ctps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (pop_data),
        .i_q_stat       (q_stat),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_edge_stamp   (o_edge_stamp),
        .o_period_last  (o_period_last),
        .o_period_low   (o_period_low),
        .o_period_high  (o_period_high),
        .o_edge_total   (o_edge_total),
        .o_period_valid (o_period_valid)
    );

endmodule
`default_nettype wire

[src/ctps_front.sv]
// Front stage: accepts capture requests, scales the latch age by the ratio
// and forms the edge timestamp before pushing into the queue. Uses ctps_pkg.
`default_nettype none
module ctps_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_req_type,
    input  wire logic [ctps_pkg::COUNT_W-1:0]  i_captured_count,
    input  wire logic [ctps_pkg::COUNT_W-1:0]  i_counter_now,
    input  wire logic [ctps_pkg::STAMP_W-1:0]  i_base_now,
    input  wire logic [ctps_pkg::RATIO_W-1:0]  i_ratio_q16,
    input  wire ctps_pkg::t_q_stat             i_q_stat,
    output logic                               o_q_push,
    output ctps_pkg::t_evt                     o_q_data
);
    import ctps_pkg::*;

    logic                 r_valid;
    logic                 n_valid;
    logic                 r_req_type;
    logic [STAMP_W-1:0]   r_base;
    logic [PERIOD_W-1:0]  r_scaled;
    logic [COUNT_W-1:0]   age;
    logic [PROD_W-1:0]    prod;
    logic                 accept;

    assign o_stall  = r_valid & i_q_stat.full;
    assign accept   = i_valid & ~o_stall;
    assign o_q_push = r_valid & ~i_q_stat.full;

    assign age  = i_counter_now - i_captured_count;
    assign prod = PROD_W'(age) * PROD_W'(i_ratio_q16);

    always_comb begin
        n_valid = accept | (r_valid & i_q_stat.full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_base     <= i_base_now;
            r_scaled   <= prod[Q_SHIFT +: PERIOD_W];
        end
    end

    always_comb begin
        o_q_data.req_type = r_req_type;
        o_q_data.stamp    = r_base - STAMP_W'(r_scaled);
    end

endmodule
`default_nettype wire

[src/ctps_queue.sv]
// Small FIFO of classified requests between the front and the back stages.
// Uses ctps_pkg for the entry and status types.
`default_nettype none
module ctps_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ctps_pkg::t_evt  i_data,
    input  wire logic            i_pop,
    output ctps_pkg::t_evt       o_data,
    output ctps_pkg::t_q_stat    o_stat
);
    import ctps_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_evt              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

[src/ctps_back.sv]
// Back stage: applies queued requests to the period statistics and holds the
// result in an output register. Uses ctps_pkg.
`default_nettype none
module ctps_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ctps_pkg::t_evt                 i_q_data,
    input  wire ctps_pkg::t_q_stat              i_q_stat,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [ctps_pkg::STAMP_W-1:0]        o_edge_stamp,
    output logic [ctps_pkg::PERIOD_W-1:0]       o_period_last,
    output logic [ctps_pkg::PERIOD_W-1:0]       o_period_low,
    output logic [ctps_pkg::PERIOD_W-1:0]       o_period_high,
    output logic [ctps_pkg::PERIOD_W-1:0]       o_edge_total,
    output logic                                o_period_valid
);
    import ctps_pkg::*;

    logic [STAMP_W-1:0]   r_prev_stamp, n_prev_stamp;
    logic                 r_have_prev,  n_have_prev;
    logic [PERIOD_W-1:0]  r_last,       n_last;
    logic [PERIOD_W-1:0]  r_min,        n_min;
    logic [PERIOD_W-1:0]  r_max,        n_max;
    logic [PERIOD_W-1:0]  r_count,      n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [PERIOD_W-1:0]  period;

    assign o_q_pop = ~i_q_stat.empty & (~r_out_valid | ~i_stall);
    assign o_valid = r_out_valid;
    assign period  = i_q_data.stamp[PERIOD_W-1:0] - r_prev_stamp[PERIOD_W-1:0];

    always_comb begin
        n_prev_stamp = r_prev_stamp;
        n_have_prev  = r_have_prev;
        n_last       = r_last;
        n_min        = r_min;
        n_max        = r_max;
        n_count      = r_count;
        if (o_q_pop) begin
            unique case (i_q_data.req_type)
                REQ_CLEAR: begin
                    n_prev_stamp = '0;
                    n_have_prev  = 1'b0;
                    n_last       = '0;
                    n_min        = PERIOD_ONES;
                    n_max        = '0;
                    n_count      = '0;
                end
                REQ_EDGE: begin
                    if (r_have_prev) begin
                        n_last = period;
                        if (period < r_min) begin
                            n_min = period;
                        end
                        if (period > r_max) begin
                            n_max = period;
                        end
                    end
                    n_prev_stamp = i_q_data.stamp;
                    n_have_prev  = 1'b1;
                    n_count      = r_count + 1'b1;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
        n_out_valid = o_q_pop | (r_out_valid & i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stamp <= '0;
            r_have_prev  <= 1'b0;
            r_last       <= '0;
            r_min        <= PERIOD_ONES;
            r_max        <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prev_stamp <= n_prev_stamp;
            r_have_prev  <= n_have_prev;
            r_last       <= n_last;
            r_min        <= n_min;
            r_max        <= n_max;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_edge_stamp   <= n_prev_stamp;
            o_period_last  <= n_last;
            o_period_low   <= n_min;
            o_period_high  <= n_max;
            o_edge_total   <= n_count;
            o_period_valid <= n_have_prev;
        end
    end

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.req_type == REQ_CLEAR) |=>
            (o_valid && !o_period_valid && o_edge_total == '0))
        else $error("clear did not reset reported statistics");

    a_edge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.req_type == REQ_EDGE) |=>
            (r_count == $past(r_count) + 1'b1 && r_have_prev))
        else $error("edge count did not advance");

    a_no_prev_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_period_valid) |-> (o_period_low == PERIOD_ONES))
        else $error("minimum period set without a previous edge");

endmodule
`default_nettype wire
